### hw/rtl/turn_limited_homing_step_unit_assert.svh
// Assertion macros shared by the homing step unit.
`ifndef TURN_LIMITED_HOMING_STEP_UNIT_ASSERT_SVH
`define TURN_LIMITED_HOMING_STEP_UNIT_ASSERT_SVH
// An implication checked at every edge outside reset.
`define THS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// An implication with a non-overlapping consequent.
`define THS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### hw/rtl/thstep_pkg.sv
`default_nettype none
package thstep_pkg;
  localparam int PosW = 24;
  localparam int VelW = 16;
  localparam int CfgW = 15;

  typedef enum logic [1:0] {
    KIND_AIM = 2'd0,
    KIND_CCW = 2'd1,
    KIND_CW  = 2'd2,
    KIND_LAUNCH = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_SPEED = 2'd0,
    CFG_COS   = 2'd1,
    CFG_SIN   = 2'd2
  } cfg_idx_t;

  // Round a Q1.15 product sum half up and saturate to 16 bits.
  function automatic logic signed [VelW-1:0] q15_rnd_sat(input logic signed [33:0] p);
    logic signed [34:0] t;
    logic signed [19:0] q;
    begin
      t = {p[33], p} + 35'sd16384;
      q = t[34:15];
      if (q > 20'sd32767) q15_rnd_sat = 16'sh7fff;
      else if (q < -20'sd32768) q15_rnd_sat = 16'sh8000;
      else q15_rnd_sat = q[VelW-1:0];
    end
  endfunction
endpackage
`default_nettype wire

### hw/rtl/thstep_divsqrt.sv
`default_nettype none
// Shared restoring unit: a square root (two bits of the radicand per cycle)
// or an unsigned division (one quotient bit per cycle).
// The finished result is presented in the cycle in which done is high.
module thstep_divsqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        is_sqrt,
  input  wire logic [51:0] num,
  input  wire logic [25:0] den,
  output logic             done,
  output logic [51:0]      res
);
  import thstep_pkg::*;

  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        sq_r, sq_nxt;
  logic [51:0] n_r, n_nxt;
  logic [53:0] rem_r, rem_nxt;
  logic [51:0] q_r, q_nxt;
  logic [25:0] d_r, d_nxt;
  logic [53:0] trial;
  logic [53:0] shr;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    sq_nxt = sq_r;
    n_nxt = n_r;
    rem_nxt = rem_r;
    q_nxt = q_r;
    d_nxt = d_r;
    done = 1'b0;
    shr = '0;
    trial = '0;
    if (start) begin
      busy_nxt = 1'b1;
      sq_nxt = is_sqrt;
      n_nxt = num;
      d_nxt = den;
      rem_nxt = '0;
      q_nxt = '0;
      cnt_nxt = is_sqrt ? 6'd26 : 6'd52;
    end else if (busy_r) begin
      if (sq_r) begin
        shr = {rem_r[51:0], n_r[51:50]};
        trial = {q_r[51:0], 2'b01};
        n_nxt = {n_r[49:0], 2'b00};
      end else begin
        shr = {rem_r[52:0], n_r[51]};
        trial = {28'd0, d_r};
        n_nxt = {n_r[50:0], 1'b0};
      end
      if (shr >= trial) begin
        rem_nxt = shr - trial;
        q_nxt = {q_r[50:0], 1'b1};
      end else begin
        rem_nxt = shr;
        q_nxt = {q_r[50:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done = 1'b1;
      end
    end
  end

  assign res = q_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    sq_r <= sq_nxt;
    n_r <= n_nxt;
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    d_r <= d_nxt;
  end
endmodule
`default_nettype wire

### hw/rtl/turn_limited_homing_step_unit.sv
`default_nettype none
// A launch request presents its result in the cycle after acceptance; a step request
// runs a square root and two divisions in the shared unit, each opened by a start
// state, then the rotate, compare and update states; when the target sits exactly
// on the pursuer, the divisions are skipped.
// Throughput: one request at a time; the next is taken the cycle after the result
// has left. Reset (synchronous, rst_n low) clears the pursuer state to zero and
// loads the default speed and turn registers.
`include "turn_limited_homing_step_unit_assert.svh"
module turn_limited_homing_step_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_cmd,
  input  wire logic signed [23:0] in_target_x,
  input  wire logic signed [23:0] in_target_y,
  input  wire logic signed [23:0] in_start_x,
  input  wire logic signed [23:0] in_start_y,
  input  wire logic signed [15:0] in_start_vx,
  input  wire logic signed [15:0] in_start_vy,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [23:0] out_pos_x,
  output logic signed [23:0] out_pos_y,
  output logic signed [15:0] out_vel_x,
  output logic signed [15:0] out_vel_y,
  output logic [1:0]       out_turn_kind
);
  import thstep_pkg::*;

  // The sequencer walks through one-hot states; every arithmetic step of a
  // request has a state of its own, and the square root and both divisions
  // share one restoring unit.
  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_SQ   = 14'b00000000000010,
    S_SQW  = 14'b00000000000100,
    S_DX   = 14'b00000000001000,
    S_DXW  = 14'b00000000010000,
    S_DY   = 14'b00000000100000,
    S_DYW  = 14'b00000001000000,
    S_ROT  = 14'b00000010000000,
    S_ROT2 = 14'b00000100000000,
    S_DOT1 = 14'b00001000000000,
    S_DOT2 = 14'b00010000000000,
    S_DOT3 = 14'b00100000000000,
    S_UPD  = 14'b01000000000000,
    S_OUT  = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CfgW-1:0] speed_r, cos_r, sin_r;
  logic signed [PosW-1:0] cx_r, cy_r;
  logic signed [VelW-1:0] cvx_r, cvy_r;
  logic signed [24:0] dx_r, dy_r;
  logic [25:0] d_r;
  logic signed [VelW-1:0] ax_r, ay_r, lx_r, ly_r, rx_r, ry_r;
  logic signed [VelW-1:0] nx_r, ny_r;
  logic [1:0] kind_r;
  logic ds_start, ds_sqrt, ds_done;
  logic [51:0] ds_num, ds_res;
  logic [24:0] mag, dxm, dym;
  logic [49:0] sqx, sqy;
  logic [39:0] prod;
  logic signed [33:0] p1, p2, p3, p4;
  logic signed [33:0] da, dl;
  logic signed [42:0] ol, or_;
  logic signed [VelW-1:0] aq;
  logic signed [24:0] sx, sy;

  thstep_divsqrt u_ds (
    .clk(clk), .rst_n(rst_n), .start(ds_start), .is_sqrt(ds_sqrt),
    .num(ds_num), .den(d_r), .done(ds_done), .res(ds_res)
  );

  assign cfg_ready = 1'b1;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // Magnitude of the active offset, squared sums, quotient rounding, rotation and dot products, next position.
  always_comb begin
    dxm = dx_r[24] ? -dx_r : dx_r;
    dym = dy_r[24] ? -dy_r : dy_r;
    mag = (state_r == S_DY || state_r == S_DYW) ? dym : dxm;
    sqx = 50'(dxm) * 50'(dxm);
    sqy = 50'(dym) * 50'(dym);
    prod = 40'(mag) * 40'(speed_r);
    ds_start = 1'b0;
    ds_sqrt = 1'b0;
    ds_num = '0;
    case (state_r)
      S_SQ: begin
        ds_start = 1'b1;
        ds_sqrt = 1'b1;
        ds_num = 52'(sqx) + 52'(sqy);
      end
      S_DX, S_DY: begin
        ds_start = 1'b1;
        ds_num = 52'(prod) + 52'(d_r >> 1);
      end
      default: ;
    endcase
    aq = VelW'(ds_res[15:0]);
    if ((state_r == S_DXW ? dx_r[24] : dy_r[24])) aq = -aq;
    p1 = 34'($signed({1'b0, cos_r})) * 34'(cvx_r);
    p2 = 34'($signed({1'b0, sin_r})) * 34'(cvy_r);
    p3 = 34'($signed({1'b0, sin_r})) * 34'(cvx_r);
    p4 = 34'($signed({1'b0, cos_r})) * 34'(cvy_r);
    da = 34'(cvx_r) * 34'(ax_r) + 34'(cvy_r) * 34'(ay_r);
    dl = 34'(cvx_r) * 34'(lx_r) + 34'(cvy_r) * 34'(ly_r);
    ol = 43'(dx_r) * 43'(lx_r) + 43'(dy_r) * 43'(ly_r);
    or_ = 43'(dx_r) * 43'(rx_r) + 43'(dy_r) * 43'(ry_r);
    sx = 25'(cx_r) + 25'(nx_r);
    sy = 25'(cy_r) + 25'(ny_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = in_cmd ? S_SQ : S_OUT;
      S_SQ:   state_nxt = S_SQW;
      S_SQW:  if (ds_done) state_nxt = (ds_res[25:0] == 26'd0) ? S_ROT : S_DX;
      S_DX:   state_nxt = S_DXW;
      S_DXW:  if (ds_done) state_nxt = S_DY;
      S_DY:   state_nxt = S_DYW;
      S_DYW:  if (ds_done) state_nxt = S_ROT;
      S_ROT:  state_nxt = S_ROT2;
      S_ROT2: state_nxt = S_DOT1;
      S_DOT1: state_nxt = S_DOT2;
      S_DOT2: state_nxt = S_DOT3;
      S_DOT3: state_nxt = S_UPD;
      S_UPD:  state_nxt = S_OUT;
      S_OUT:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      speed_r <= 15'd1280;
      cos_r <= 15'd32742;
      sin_r <= 15'd412;
      cx_r <= '0;
      cy_r <= '0;
      cvx_r <= '0;
      cvy_r <= '0;
      kind_r <= KIND_AIM;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SPEED: speed_r <= cfg_data;
          CFG_COS:   cos_r <= cfg_data;
          CFG_SIN:   sin_r <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (!in_cmd) begin
              cx_r <= in_start_x;
              cy_r <= in_start_y;
              cvx_r <= in_start_vx;
              cvy_r <= in_start_vy;
              kind_r <= KIND_LAUNCH;
            end
            dx_r <= 25'(in_target_x) - 25'(cx_r);
            dy_r <= 25'(in_target_y) - 25'(cy_r);
            ax_r <= '0;
            ay_r <= '0;
          end
        end
        S_SQW: if (ds_done) d_r <= ds_res[25:0];
        S_DXW: if (ds_done) ax_r <= aq;
        S_DYW: if (ds_done) ay_r <= aq;
        S_ROT: begin
          lx_r <= q15_rnd_sat(p1 - p2);
          ly_r <= q15_rnd_sat(p3 + p4);
        end
        S_ROT2: begin
          rx_r <= q15_rnd_sat(p1 + p2);
          ry_r <= q15_rnd_sat(p4 - p3);
        end
        S_DOT1: begin
          if (da >= dl) begin
            nx_r <= ax_r; ny_r <= ay_r; kind_r <= KIND_AIM;
          end else if (ol >= or_) begin
            nx_r <= lx_r; ny_r <= ly_r; kind_r <= KIND_CCW;
          end else begin
            nx_r <= rx_r; ny_r <= ry_r; kind_r <= KIND_CW;
          end
        end
        S_UPD: begin
          cvx_r <= nx_r;
          cvy_r <= ny_r;
          cx_r <= (sx > 25'sd8388607) ? 24'sh7fffff :
                  (sx < -25'sd8388608) ? 24'sh800000 : sx[23:0];
          cy_r <= (sy > 25'sd8388607) ? 24'sh7fffff :
                  (sy < -25'sd8388608) ? 24'sh800000 : sy[23:0];
        end
        default: ;
      endcase
    end
  end

  assign out_pos_x = cx_r;
  assign out_pos_y = cy_r;
  assign out_vel_x = cvx_r;
  assign out_vel_y = cvy_r;
  assign out_turn_kind = kind_r;

  `THS_ASSERT_IMP(a_one_side, in_ready, !out_valid)
  `THS_ASSERT_NXT(a_launch_goes_out, in_valid && in_ready && !in_cmd,
    out_valid && out_turn_kind == KIND_LAUNCH)
  `THS_ASSERT_NXT(a_out_holds, out_valid && !out_ready, out_valid && $stable(out_pos_x))
endmodule
`default_nettype wire

### sim/thstep_checker.sv
`timescale 1ns / 100ps
// Watches the register, request and result channels of the homing step unit,
// keeps its own copy of the pursuer state and settings, and compares each
// result with the oldest outstanding prediction.
module thstep_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [14:0]        cfg_data,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic               in_cmd,
  input  wire logic signed [23:0] in_target_x,
  input  wire logic signed [23:0] in_target_y,
  input  wire logic signed [23:0] in_start_x,
  input  wire logic signed [23:0] in_start_y,
  input  wire logic signed [15:0] in_start_vx,
  input  wire logic signed [15:0] in_start_vy,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic signed [23:0] out_pos_x,
  input  wire logic signed [23:0] out_pos_y,
  input  wire logic signed [15:0] out_vel_x,
  input  wire logic signed [15:0] out_vel_y,
  input  wire logic [1:0]         out_turn_kind,
  output int                      fail_count,
  output int                      pending_n,
  output int                      aimed_n,
  output int                      ccw_n,
  output int                      cw_n
);
  import thstep_pkg::*;

  typedef struct {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    kind_t              kind;
  } pursuit_state_t;

  localparam longint PosHi = 8388607;
  localparam longint PosLo = -8388608;
  localparam longint VelHi = 32767;
  localparam longint VelLo = -32768;

  longint speed_q, cos_q, sin_q;
  longint px, py, pvx, pvy;
  pursuit_state_t expected_q[$];

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    clamp = (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint int_sqrt(input longint n);
    longint root, bitv;
    root = 0;
    bitv = longint'(1) << 60;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    int_sqrt = root;
  endfunction

  // Scaled direction component, rounded to nearest with halves away from zero.
  function automatic longint aim_part(input longint diff, input longint reach);
    longint mag, q;
    mag = (diff < 0) ? -diff : diff;
    q = (mag * speed_q + reach / 2) / reach;
    aim_part = (diff < 0) ? -q : q;
  endfunction

  // Q1.15 products back to Q7.8, rounded half up and saturated.
  function automatic longint rot_round(input longint p);
    rot_round = clamp((p + 16384) >>> 15, VelLo, VelHi);
  endfunction

  function automatic pursuit_state_t steer_step(
    input logic cmd,
    input logic signed [23:0] tx, input logic signed [23:0] ty,
    input logic signed [23:0] sx, input logic signed [23:0] sy,
    input logic signed [15:0] svx, input logic signed [15:0] svy);
    longint dx, dy, reach, ax, ay, lx, ly, rx, ry, nx, ny;
    kind_t k;
    pursuit_state_t r;
    if (!cmd) begin
      px = sx; py = sy; pvx = svx; pvy = svy;
      k = KIND_LAUNCH;
    end else begin
      dx = longint'(tx) - px;
      dy = longint'(ty) - py;
      reach = int_sqrt(dx * dx + dy * dy);
      ax = 0;
      ay = 0;
      if (reach != 0) begin
        ax = aim_part(dx, reach);
        ay = aim_part(dy, reach);
      end
      lx = rot_round(cos_q * pvx - sin_q * pvy);
      ly = rot_round(sin_q * pvx + cos_q * pvy);
      rx = rot_round(cos_q * pvx + sin_q * pvy);
      ry = rot_round(cos_q * pvy - sin_q * pvx);
      if (pvx * ax + pvy * ay >= pvx * lx + pvy * ly) begin
        nx = ax; ny = ay; k = KIND_AIM;
      end else if (dx * lx + dy * ly >= dx * rx + dy * ry) begin
        nx = lx; ny = ly; k = KIND_CCW;
      end else begin
        nx = rx; ny = ry; k = KIND_CW;
      end
      pvx = nx;
      pvy = ny;
      px = clamp(px + nx, PosLo, PosHi);
      py = clamp(py + ny, PosLo, PosHi);
    end
    r.pos_x = px[23:0];
    r.pos_y = py[23:0];
    r.vel_x = pvx[15:0];
    r.vel_y = pvy[15:0];
    r.kind = k;
    steer_step = r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    if (fail_count < 40)
      $display("mismatch at %0t: %s got %0d, want %0d", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    aimed_n = 0;
    ccw_n = 0;
    cw_n = 0;
    pending_n = 0;
  end

  always @(posedge clk) begin
    pursuit_state_t want;
    if (!rst_n) begin
      speed_q = 1280;
      cos_q = 32742;
      sin_q = 412;
      px = 0; py = 0; pvx = 0; pvy = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SPEED: speed_q = cfg_data;
          CFG_COS:   cos_q = cfg_data;
          CFG_SIN:   sin_q = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_q.push_back(steer_step(in_cmd, in_target_x, in_target_y,
                                        in_start_x, in_start_y, in_start_vx, in_start_vy));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", out_turn_kind, -1);
        end else begin
          want = expected_q.pop_front();
          if (out_pos_x !== want.pos_x) report("pos_x", out_pos_x, want.pos_x);
          if (out_pos_y !== want.pos_y) report("pos_y", out_pos_y, want.pos_y);
          if (out_vel_x !== want.vel_x) report("vel_x", out_vel_x, want.vel_x);
          if (out_vel_y !== want.vel_y) report("vel_y", out_vel_y, want.vel_y);
          if (out_turn_kind !== want.kind) report("turn_kind", out_turn_kind, want.kind);
          case (want.kind)
            KIND_AIM: aimed_n++;
            KIND_CCW: ccw_n++;
            KIND_CW:  cw_n++;
            default: ;
          endcase
        end
      end
    end
    pending_n = expected_q.size();
  end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// Top of the homing step bench. It makes the stimulus, drives the register
// port, paces the result side, and gives the verdict; all prediction and
// comparison live in the checker beside the block.
module tb;
  import thstep_pkg::*;

  // Index three lies beyond the register list; writes to it must be ignored.
  localparam logic [1:0] CfgUnused = 2'd3;
  localparam int CycleLimit = 1000000;
  localparam int PosMax = 8388607;
  localparam int PosMin = -8388608;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [14:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = 1'b0;
  logic signed [23:0] in_target_x = '0, in_target_y = '0;
  logic signed [23:0] in_start_x = '0, in_start_y = '0;
  logic signed [15:0] in_start_vx = '0, in_start_vy = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [23:0] out_pos_x, out_pos_y;
  logic signed [15:0] out_vel_x, out_vel_y;
  logic [1:0] out_turn_kind;

  int fail_count, pending_n, aimed_n, ccw_n, cw_n;
  int cycles = 0;
  int sent_n = 0;
  int launch_n = 0;
  int setting_n = 0;
  int results_n = 0;
  // Where the last launch put the pursuer, so that targets can be placed near it.
  int base_x = 0;
  int base_y = 0;

  always #5 clk = ~clk;

  turn_limited_homing_step_unit DUT (.*);

  thstep_checker u_checker (.*);

  // The run is stopped outright if it drags on far beyond any sane length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: the ready pattern switches at random between always ready, mild
  // and heavy stalling. Once, after a few hundred results, the receiver holds off
  // for a long stretch so that the block stays full and the sender is left waiting
  // with its request on the channel.
  initial begin
    int mode;
    int hold_left;
    bit held;
    mode = 0;
    hold_left = 0;
    held = 1'b0;
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) results_n++;
      if (cycles % 64 == 0) mode = $urandom_range(0, 2);
      if (!held && results_n >= 300) begin
        held = 1'b1;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_steering(input logic [14:0] spd, input logic [14:0] c,
                              input logic [14:0] s);
    write_reg(CFG_SPEED, spd);
    write_reg(CFG_COS, c);
    write_reg(CFG_SIN, s);
    setting_n++;
  endtask

  // Registers change only with nothing in flight.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_n != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // Offers one request and returns once it has been taken. Valid is left high
  // so that a following request in the same burst goes straight out.
  task automatic offer(input logic cmd,
                       input int tx, input int ty, input int sx, input int sy,
                       input int svx, input int svy);
    in_cmd <= cmd;
    in_target_x <= tx[23:0];
    in_target_y <= ty[23:0];
    in_start_x <= sx[23:0];
    in_start_y <= sy[23:0];
    in_start_vx <= svx[15:0];
    in_start_vy <= svy[15:0];
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_n++;
    if (!cmd) begin
      launch_n++;
      base_x = sx;
      base_y = sy;
    end
  endtask

  function automatic int any_pos();
    any_pos = int'($signed($urandom() & 32'hffffff) <<< 8) >>> 8;
  endfunction

  function automatic int any_vel();
    any_vel = int'(($urandom() & 32'hffff) ^ 32'h8000) - 32768;
  endfunction

  function automatic int near(input int centre, input int span);
    longint v;
    v = longint'(centre) + $urandom_range(0, 2 * span) - span;
    if (v > PosMax) v = PosMax;
    if (v < PosMin) v = PosMin;
    near = int'(v);
  endfunction

  task automatic launch_at(input int sx, input int sy, input int svx, input int svy);
    offer(1'b0, any_pos(), any_pos(), sx, sy, svx, svy);
  endtask

  task automatic step_to(input int tx, input int ty);
    offer(1'b1, tx, ty, any_pos(), any_pos(), any_vel(), any_vel());
  endtask

  // One pursuit: a launch followed by steps. Most start close to the origin at
  // modest speeds with targets nearby, so that the turn limit actually bites;
  // some use the full range. A few steps come with no launch at all.
  task automatic random_pursuit(output int count);
    int steps, sx, sy, tx, ty, span;
    bit wide;
    count = 0;
    wide = ($urandom_range(0, 4) == 0);
    span = wide ? 8000000 : $urandom_range(256, 40000);
    if ($urandom_range(0, 9) != 0) begin
      sx = wide ? any_pos() : near(0, 100000);
      sy = wide ? any_pos() : near(0, 100000);
      if (wide) launch_at(sx, sy, any_vel(), any_vel());
      else if ($urandom_range(0, 7) == 0) launch_at(sx, sy, 0, 0);
      else launch_at(sx, sy, $urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000);
      count++;
    end
    steps = $urandom_range(1, 12);
    tx = near(base_x, span);
    ty = near(base_y, span);
    repeat (steps) begin
      if ($urandom_range(0, 5) == 0) step_to(any_pos(), any_pos());
      else step_to(near(tx, span / 8 + 1), near(ty, span / 8 + 1));
      count++;
    end
  endtask

  task automatic random_phase(input int items);
    int done, burst, got;
    done = 0;
    burst = 0;
    while (done < items) begin
      if (burst == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
        burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
      end
      random_pursuit(got);
      done += got;
      burst = (burst > got) ? burst - got : 0;
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, under the reset settings. A fresh launch with zero
    // velocity, a target sitting exactly on the pursuer, then a far target.
    launch_at(0, 0, 0, 0);
    step_to(0, 0);
    step_to(PosMax, PosMax);
    // Full-scale corner launches with extreme velocities.
    launch_at(PosMax, PosMax, 32767, 32767);
    step_to(PosMax, PosMax);
    launch_at(PosMin, PosMin, -32768, -32768);
    step_to(PosMax, PosMin);
    step_to(PosMin, PosMax);
    // Target behind the pursuer, just to one side and then the other.
    launch_at(0, 0, 1280, 0);
    step_to(-1000, 1);
    launch_at(0, 0, 1280, 0);
    step_to(-1000, -1);
    // Position saturation at both ends.
    launch_at(PosMax - 10, PosMin + 10, 32767, -32768);
    step_to(PosMax, PosMin);
    launch_at(PosMin + 3, PosMax - 3, -30000, 30000);
    step_to(PosMin, PosMax);
    drain();

    // Zero speed, then extreme turn settings; index three must change nothing.
    set_steering(15'd0, 15'd32767, 15'd0);
    write_reg(CfgUnused, 15'h7fff);
    launch_at(100, 100, 500, -500);
    step_to(-5000, 7000);
    step_to(100, 100);
    drain();
    set_steering(15'd32767, 15'd0, 15'd32767);
    launch_at(0, 0, 32767, -32768);
    step_to(PosMax, PosMax);
    step_to(-PosMax, 12);
    drain();

    random_phase(250);
    set_steering(15'd32767, 15'd32767, 15'd32767);
    random_phase(250);
    set_steering(15'd0, 15'd0, 15'd0);
    random_phase(200);
    set_steering(15'd256, 15'd23170, 15'd23170);
    random_phase(250);
    set_steering(15'($urandom()), 15'($urandom()), 15'($urandom()));
    write_reg(CfgUnused, 15'($urandom()));
    random_phase(250);
    set_steering(15'd1280, 15'd32742, 15'd412);
    random_phase(300);

    drain();
    repeat (20) @(posedge clk);
    $display("Covered %0d requests (%0d launches) over %0d register settings.",
             sent_n, launch_n, setting_n + 1);
    $display("Steps aimed directly %0d, limited counter-clockwise %0d, clockwise %0d.",
             aimed_n, ccw_n, cw_n);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### turn_limited_homing_step_unit.f
+incdir+hw/rtl
hw/rtl/thstep_pkg.sv
hw/rtl/thstep_divsqrt.sv
hw/rtl/turn_limited_homing_step_unit.sv
sim/thstep_checker.sv
sim/tb.sv
